// File: rtl/clpdr_pkg.sv
// Shared types and constants of the ordered byte store.
package clpdr_pkg;

  localparam int unsigned DEPTH_DEF = 32;

  // Command codes carried on the request word.
  typedef enum logic [2:0] {
    CMD_PUSH = 3'd0,
    CMD_DEL  = 3'd1,
    CMD_FWD  = 3'd2,
    CMD_REV  = 3'd3,
    CMD_CLR  = 3'd4
  } cmd_e;

  // Status codes returned on the response word.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_MARK,
    S_SORT,
    S_READ
  } fsm_e;

  // What every cell of the chain does in the current cycle.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_PUSH,
    OP_MARK,
    OP_SORT,
    OP_FWD,
    OP_REV
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       phase;
    logic [7:0] key;
  } cell_ctrl_t;

endpackage

// File: rtl/clpdr_ifs.sv
// Request and response channel interfaces of the ordered byte store.
interface clpdr_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] item_value;

  modport source (output valid, output cmd, output item_value, input ready);
  modport sink   (input valid, input cmd, input item_value, output ready);
endinterface

interface clpdr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_value;
  logic       has_entry;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_value, output has_entry, output status,
                  output last, input ready);
  modport sink   (input valid, input out_value, input has_entry, input status,
                  input last, output ready);
endinterface

// File: rtl/clpdr_cell.sv
// One storage cell of the chain: a byte, a hole flag and the neighbor moves.
module clpdr_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 6
) (
  input  logic                  clk_i,
  input  clpdr_pkg::cell_ctrl_t ctrl_i,
  input  logic [CW-1:0]         cnt_i,
  input  logic [7:0]            head_i,
  input  logic [7:0]            left_data_i,
  input  logic                  left_hole_i,
  input  logic [7:0]            right_data_i,
  input  logic                  right_hole_i,
  output logic [7:0]            data_o,
  output logic                  hole_o,
  output logic [7:0]            tail_data_o
);

  localparam logic ODD = 1'(IDX % 2);

  logic [7:0] data_q, data_d;
  logic       hole_q, hole_d;
  logic       occ, is_tail;

  assign occ     = CW'(IDX) < cnt_i;
  assign is_tail = cnt_i == CW'(IDX + 1);

  always_comb begin
    data_d = data_q;
    hole_d = hole_q;
    case (ctrl_i.op)
      clpdr_pkg::OP_PUSH: data_d = left_data_i;
      clpdr_pkg::OP_MARK: hole_d = !occ || (data_q == ctrl_i.key);
      clpdr_pkg::OP_SORT: begin
        // odd-even transposition on the hole flag; kept bytes never pass each other
        if (ctrl_i.phase == ODD) begin
          if (hole_q && !right_hole_i) begin
            data_d = right_data_i;
            hole_d = 1'b0;
          end
        end else if (left_hole_i && !hole_q) begin
          data_d = left_data_i;
          hole_d = 1'b1;
        end
      end
      clpdr_pkg::OP_FWD:  data_d = is_tail ? head_i : right_data_i;
      clpdr_pkg::OP_REV:  data_d = left_data_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    hole_q <= hole_d;
  end

  assign data_o      = data_q;
  assign hole_o      = hole_q;
  assign tail_data_o = is_tail ? data_q : 8'h00;

endmodule

// File: rtl/char_list_push_delete_readout_unit.sv
// Top level of the ordered byte store: controller, cell chain and response register.
//
// Ordered store of up to DEPTH bytes held in a row of cells, cell 0 being the
// head. Push-front shifts the whole row one cell toward the tail in the cycle
// the request word is accepted; clear only resets the fill count. Both answer
// with one word. Delete marks every matching or unused cell as a hole, then
// runs DEPTH rounds of odd-even exchanges between neighbor cells that move the
// holes to the tail while kept bytes keep their order; the new fill count is
// tallied over the same rounds. Readout of n entries gives one word per cycle
// while the output register can take it, taken from cell 0 (forward) or from
// the tail cell (reverse), and the occupied part of the row rotates by one
// cell per word, so after n words the row is back in place. An empty readout
// gives one word with status empty. Unused command codes are dropped without a
// response. A new request word is taken while the previous response word still
// waits in the output register. Cell contents need no clearing after reset and
// are not reset; the fill count and the controller state are.
module char_list_push_delete_readout_unit #(
  parameter int unsigned DEPTH = clpdr_pkg::DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  clpdr_req_if.sink    req_i,
  clpdr_rsp_if.source  rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);  // fill count
  localparam int unsigned RW = $clog2(DEPTH);      // sort round

  clpdr_pkg::fsm_e state_q, state_d;

  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    rem_q, rem_d;
  logic [CW-1:0]    kept_q, kept_d;
  logic [RW-1:0]    rnd_q, rnd_d;
  logic [DEPTH-1:0] scan_q, scan_d;
  logic [7:0]       key_q, key_d;
  logic             rev_q, rev_d;
  logic [1:0]       resp_q, resp_d;

  logic             ov_q, ov_d;
  logic [7:0]       oval_q, oval_d;
  logic             ohas_q, ohas_d;
  logic [1:0]       ost_q, ost_d;
  logic             olast_q, olast_d;

  logic             slot_free;
  logic             kbit;
  logic [CW-1:0]    kept_nx;
  logic [7:0]       tail_bus;

  clpdr_pkg::cell_ctrl_t ctrl;

  logic [7:0]       data_w [DEPTH];
  logic [7:0]       tdat_w [DEPTH];
  logic [DEPTH-1:0] hole_w;

  // ---------------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [7:0] ld, rd;
    logic       lh, rh;

    if (i == 0) begin : g_head
      // head takes the new byte on push, the tail byte on reverse rotation
      assign ld = (ctrl.op == clpdr_pkg::OP_REV) ? tail_bus : ctrl.key;
      assign lh = 1'b0;
    end else begin : g_mid
      assign ld = data_w[i-1];
      assign lh = hole_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign rd = 8'h00;
      assign rh = 1'b1;
    end else begin : g_body
      assign rd = data_w[i+1];
      assign rh = hole_w[i+1];
    end

    clpdr_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .cnt_i        (count_q),
      .head_i       (data_w[0]),
      .left_data_i  (ld),
      .left_hole_i  (lh),
      .right_data_i (rd),
      .right_hole_i (rh),
      .data_o       (data_w[i]),
      .hole_o       (hole_w[i]),
      .tail_data_o  (tdat_w[i])
    );
  end

  // only the tail cell drives a nonzero byte
  always_comb begin
    tail_bus = 8'h00;
    for (int i = 0; i < DEPTH; i++) begin
      tail_bus = tail_bus | tdat_w[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Controller
  // ---------------------------------------------------------------------------
  assign slot_free = !ov_q || rsp_o.ready;
  assign req_i.ready = (state_q == clpdr_pkg::S_IDLE);

  // kept-entry tally: first round reads the fresh hole flags, later rounds the shifted copy
  assign kbit    = (rnd_q == '0) ? !hole_w[0] : scan_q[0];
  assign kept_nx = kept_q + CW'(kbit);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    rem_d   = rem_q;
    kept_d  = kept_q;
    rnd_d   = rnd_q;
    scan_d  = scan_q;
    key_d   = key_q;
    rev_d   = rev_q;
    resp_d  = resp_q;

    ov_d    = ov_q && !rsp_o.ready;
    oval_d  = oval_q;
    ohas_d  = ohas_q;
    ost_d   = ost_q;
    olast_d = olast_q;

    ctrl.op    = clpdr_pkg::OP_HOLD;
    ctrl.phase = rnd_q[0];
    ctrl.key   = (state_q == clpdr_pkg::S_IDLE) ? req_i.item_value : key_q;

    case (state_q)
      clpdr_pkg::S_IDLE: begin
        if (req_i.valid) begin
          key_d = req_i.item_value;
          case (clpdr_pkg::cmd_e'(req_i.cmd))
            clpdr_pkg::CMD_PUSH: begin
              if (count_q == CW'(DEPTH)) begin
                resp_d = clpdr_pkg::ST_FULL;
              end else begin
                ctrl.op = clpdr_pkg::OP_PUSH;
                count_d = count_q + CW'(1);
                resp_d  = clpdr_pkg::ST_OK;
              end
              state_d = clpdr_pkg::S_RESP;
            end
            clpdr_pkg::CMD_DEL: begin
              state_d = clpdr_pkg::S_MARK;
            end
            clpdr_pkg::CMD_FWD, clpdr_pkg::CMD_REV: begin
              rev_d = (clpdr_pkg::cmd_e'(req_i.cmd) == clpdr_pkg::CMD_REV);
              if (count_q == '0) begin
                resp_d  = clpdr_pkg::ST_EMPTY;
                state_d = clpdr_pkg::S_RESP;
              end else begin
                rem_d   = count_q;
                state_d = clpdr_pkg::S_READ;
              end
            end
            clpdr_pkg::CMD_CLR: begin
              count_d = '0;
              resp_d  = clpdr_pkg::ST_OK;
              state_d = clpdr_pkg::S_RESP;
            end
            default: ;  // unused codes: no response
          endcase
        end
      end

      clpdr_pkg::S_RESP: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          oval_d  = 8'h00;
          ohas_d  = 1'b0;
          ost_d   = resp_q;
          olast_d = 1'b1;
          state_d = clpdr_pkg::S_IDLE;
        end
      end

      clpdr_pkg::S_MARK: begin
        ctrl.op = clpdr_pkg::OP_MARK;
        rnd_d   = '0;
        kept_d  = '0;
        state_d = clpdr_pkg::S_SORT;
      end

      clpdr_pkg::S_SORT: begin
        ctrl.op = clpdr_pkg::OP_SORT;
        kept_d  = kept_nx;
        scan_d  = (rnd_q == '0) ? ((~hole_w) >> 1) : (scan_q >> 1);
        if (rnd_q == RW'(DEPTH - 1)) begin
          count_d = kept_nx;
          resp_d  = (kept_nx == count_q) ? clpdr_pkg::ST_NOT_FOUND : clpdr_pkg::ST_OK;
          state_d = clpdr_pkg::S_RESP;
        end else begin
          rnd_d = rnd_q + RW'(1);
        end
      end

      clpdr_pkg::S_READ: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          oval_d  = rev_q ? tail_bus : data_w[0];
          ohas_d  = 1'b1;
          ost_d   = clpdr_pkg::ST_OK;
          olast_d = (rem_q == CW'(1));
          ctrl.op = rev_q ? clpdr_pkg::OP_REV : clpdr_pkg::OP_FWD;
          rem_d   = rem_q - CW'(1);
          if (rem_q == CW'(1)) begin
            state_d = clpdr_pkg::S_IDLE;
          end
        end
      end

      default: state_d = clpdr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clpdr_pkg::S_IDLE;
      count_q <= '0;
      rem_q   <= '0;
      kept_q  <= '0;
      rnd_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      kept_q  <= kept_d;
      rnd_q   <= rnd_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    scan_q  <= scan_d;
    key_q   <= key_d;
    rev_q   <= rev_d;
    resp_q  <= resp_d;
    oval_q  <= oval_d;
    ohas_q  <= ohas_d;
    ost_q   <= ost_d;
    olast_q <= olast_d;
  end

  assign rsp_o.valid     = ov_q;
  assign rsp_o.out_value = oval_q;
  assign rsp_o.has_entry = ohas_q;
  assign rsp_o.status    = ost_q;
  assign rsp_o.last      = olast_q;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count above depth");

  a_read_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == clpdr_pkg::S_READ |-> rem_q != '0)
    else $error("readout running with nothing left");

  a_push_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready && req_i.cmd == clpdr_pkg::CMD_PUSH
      && count_q != CW'(DEPTH)
    |=> count_q == $past(count_q) + CW'(1))
    else $error("push did not grow the store");

  a_del_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == clpdr_pkg::S_SORT && rnd_q == RW'(DEPTH - 1)
    |=> count_q <= $past(count_q))
    else $error("delete grew the store");

  a_entry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && ohas_q |-> ost_q == clpdr_pkg::ST_OK)
    else $error("entry word with non-ok status");
`endif

endmodule
